@@ design/rsbf_pkg.sv @@
package rsbf_pkg;

	localparam int MAX_WINDOW   = 64;
	localparam int MAX_CHANNELS = 4;

	localparam int SAMPLE_W    = 8;
	localparam int WIN_W       = 7;
	localparam int CHAN_CNT_W  = 3;
	localparam int CH_W        = 2;
	localparam int SUM_W       = 14;
	localparam int POS_W       = 9;
	localparam int SPAN_W      = 10;
	localparam int NUM_SUMS    = 4;
	localparam int DELAY_DEPTH = 256;
	localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_DATA_W  = WIN_W;
	localparam int CFG_IDX_W   = 1;

	localparam logic [WIN_W-1:0]      WINDOW_RESET   = WIN_W'(6 + 5);
	localparam logic [CHAN_CNT_W-1:0] CHANNELS_RESET = CHAN_CNT_W'(3);

	// Once the window is known to be full the position stops at the top and
	// restarts at the delay depth, so the full condition stays true.
	localparam logic [POS_W-1:0] POS_MAX     = POS_W'(511);
	localparam logic [POS_W-1:0] POS_RESTART = POS_W'(DELAY_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW   = 1'b0,
		REG_CHANNELS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [WIN_W-1:0] window;
		logic [CH_W-1:0]  ch;
		logic             last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] v);
		logic [WIN_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = WIN_W'(1);
		end else if (int'(v) > MAX_WINDOW) begin
			r = WIN_W'(MAX_WINDOW);
		end
		return r;
	endfunction

	function automatic logic [CHAN_CNT_W-1:0] clamp_channels(input logic [CHAN_CNT_W-1:0] v);
		logic [CHAN_CNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CHAN_CNT_W'(1);
		end else if (int'(v) > MAX_CHANNELS) begin
			r = CHAN_CNT_W'(MAX_CHANNELS);
		end
		return r;
	endfunction

endpackage

@@ design/rsbf_in_if.sv @@
interface rsbf_in_if;
	logic                           valid;
	logic                           ready;
	logic [rsbf_pkg::SAMPLE_W-1:0]  sample;
	logic                           line_end;

	modport source (output valid, output sample, output line_end, input ready);
	modport sink (input valid, input sample, input line_end, output ready);
endinterface

@@ design/rsbf_out_if.sv @@
interface rsbf_out_if;
	logic                           valid;
	logic                           ready;
	logic [rsbf_pkg::SAMPLE_W-1:0]  average;
	logic [rsbf_pkg::CH_W-1:0]      channel;
	logic                           line_last;

	modport source (output valid, output average, output channel, output line_last,
		input ready);
	modport sink (input valid, input average, input channel, input line_last,
		output ready);
endinterface

@@ design/rsbf_ram.sv @@
module rsbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when both ports hit the same entry.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

@@ design/rsbf_queue.sv @@
module rsbf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rsbf_pkg::entry_t  push_entry,
	input  logic              pop,
	output rsbf_pkg::entry_t  pop_entry,
	output rsbf_pkg::q_stat_t stat
);

	localparam int DEPTH = rsbf_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rsbf_pkg::entry_t  slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_entry  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ design/rsbf_front.sv @@
module rsbf_front (
	input  logic                              clk,
	input  logic                              arst_n,
	rsbf_in_if.sink                           src,
	input  logic [rsbf_pkg::WIN_W-1:0]        window_size,
	input  logic [rsbf_pkg::CHAN_CNT_W-1:0]   channel_count,
	input  rsbf_pkg::q_stat_t                 q_stat,
	output logic                              q_push,
	output rsbf_pkg::entry_t                  q_entry
);

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} state_t;

	state_t                            state_q;
	logic [rsbf_pkg::POS_W-1:0]        pos_q;
	logic [rsbf_pkg::CH_W-1:0]         idx_q;
	logic [rsbf_pkg::SUM_W-1:0]        sums_q [rsbf_pkg::NUM_SUMS];

	logic [rsbf_pkg::SAMPLE_W-1:0]     sample_s1;
	logic                              last_s1;
	logic [rsbf_pkg::CH_W-1:0]         ch_s1;
	logic                              hit_s1;
	logic [rsbf_pkg::WIN_W-1:0]        w_s1;

	logic                              accept;
	logic [rsbf_pkg::WIN_W-1:0]        w_clamp;
	logic [rsbf_pkg::CHAN_CNT_W-1:0]   c_clamp;
	logic [rsbf_pkg::SPAN_W-1:0]       span;
	logic                              hit;
	logic [rsbf_pkg::CH_W-1:0]         ch_cur;
	logic [rsbf_pkg::CHAN_CNT_W-1:0]   idx_inc;
	logic [rsbf_pkg::CH_W-1:0]         idx_next;
	logic [rsbf_pkg::POS_W-1:0]        pos_next;
	logic [rsbf_pkg::DELAY_AW-1:0]     old_addr;
	logic [rsbf_pkg::SAMPLE_W-1:0]     old_byte;
	logic [rsbf_pkg::SUM_W-1:0]        sum_new;

	// Space in the queue is checked before the item is taken, so the push in
	// the following cycle always finds a free slot.
	assign src.ready = (state_q == ST_IDLE) && !q_stat.full;
	assign accept    = src.valid && src.ready;

	assign w_clamp  = rsbf_pkg::clamp_window(window_size);
	assign c_clamp  = rsbf_pkg::clamp_channels(channel_count);
	assign span     = rsbf_pkg::SPAN_W'(w_clamp) * rsbf_pkg::SPAN_W'(c_clamp);
	assign hit      = rsbf_pkg::SPAN_W'(pos_q) >= span;
	assign ch_cur   = (rsbf_pkg::CHAN_CNT_W'(idx_q) >= c_clamp) ? '0 : idx_q;
	assign idx_inc  = rsbf_pkg::CHAN_CNT_W'(ch_cur) + 1'b1;
	assign idx_next = (idx_inc >= c_clamp) ? '0 : idx_inc[rsbf_pkg::CH_W-1:0];
	assign pos_next = (pos_q == rsbf_pkg::POS_MAX) ? rsbf_pkg::POS_RESTART : pos_q + 1'b1;
	assign old_addr = rsbf_pkg::DELAY_AW'(rsbf_pkg::SPAN_W'(pos_q) - span);

	rsbf_ram #(
		.WIDTH (rsbf_pkg::SAMPLE_W),
		.DEPTH (rsbf_pkg::DELAY_DEPTH)
	) u_delay (
		.clk   (clk),
		.we    (accept),
		.waddr (pos_q[rsbf_pkg::DELAY_AW-1:0]),
		.wdata (src.sample),
		.raddr (old_addr),
		.rdata (old_byte)
	);

	assign sum_new = sums_q[ch_s1] + rsbf_pkg::SUM_W'(sample_s1)
		- (hit_s1 ? rsbf_pkg::SUM_W'(old_byte) : '0);

	assign q_push         = (state_q == ST_CALC) && hit_s1;
	assign q_entry.sum    = sum_new;
	assign q_entry.window = w_s1;
	assign q_entry.ch     = ch_s1;
	assign q_entry.last   = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			idx_q   <= '0;
			for (int i = 0; i < rsbf_pkg::NUM_SUMS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q   <= pos_next;
						idx_q   <= idx_next;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (last_s1) begin
						pos_q <= '0;
						idx_q <= '0;
						for (int i = 0; i < rsbf_pkg::NUM_SUMS; i++) begin
							sums_q[i] <= '0;
						end
					end else begin
						sums_q[ch_s1] <= sum_new;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= src.sample;
			last_s1   <= src.line_end;
			ch_s1     <= ch_cur;
			hit_s1    <= hit;
			w_s1      <= w_clamp;
		end
	end

endmodule

@@ design/rsbf_back.sv @@
module rsbf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rsbf_pkg::q_stat_t q_stat,
	input  rsbf_pkg::entry_t  q_entry,
	output logic              q_pop,
	rsbf_out_if.source        dst
);

	localparam int SUM_W = rsbf_pkg::SUM_W;
	localparam int WIN_W = rsbf_pkg::WIN_W;
	localparam int CNT_W = $clog2(SUM_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               step_q;
	logic [SUM_W-1:0]               quot_q;
	logic [WIN_W-1:0]               rem_q;
	logic [WIN_W-1:0]               div_q;
	logic [rsbf_pkg::CH_W-1:0]      ch_q;
	logic                           last_q;

	logic [WIN_W:0]                 trial;
	logic                           ge;
	logic [WIN_W:0]                 diff;
	logic [WIN_W-1:0]               rem_next;
	logic                           load_out;
	logic [rsbf_pkg::SAMPLE_W-1:0]  avg_sat;

	assign q_pop    = (state_q == ST_IDLE) && !q_stat.empty;
	assign load_out = (state_q == ST_DONE) && (!dst.valid || dst.ready);

	// Restoring division, one quotient bit per cycle, most significant first.
	assign trial    = {rem_q, quot_q[SUM_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];

	assign avg_sat = (quot_q > SUM_W'(255)) ? '1 : quot_q[rsbf_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			dst.valid <= 1'b0;
		end else begin
			if (dst.valid && dst.ready && !load_out) begin
				dst.valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						step_q  <= CNT_W'(SUM_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						dst.valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			quot_q <= q_entry.sum;
			rem_q  <= '0;
			div_q  <= q_entry.window;
			ch_q   <= q_entry.ch;
			last_q <= q_entry.last;
		end else if (state_q == ST_DIV) begin
			quot_q <= {quot_q[SUM_W-2:0], ge};
			rem_q  <= rem_next;
		end
		if (load_out) begin
			dst.average   <= avg_sat;
			dst.channel   <= ch_q;
			dst.line_last <= last_q;
		end
	end

endmodule

@@ design/running_sum_box_filter.sv @@
// Box filter over interleaved pixel bytes, one running sum per channel.
// Input side: an item goes through a delay line read, then a sum update, and
// the next item is taken only after the update and while the queue has space.
// Result side: the 14-step serial divider sets the rate; the next queue entry is
// taken only once the last result has been loaded into the output register.
// Asynchronous active-low reset clears sums, position, queue and handshakes;
// the delay line is not cleared, reads only reach bytes of the current line.
module running_sum_box_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	rsbf_in_if.sink                          pixels,
	rsbf_out_if.source                       results,
	input  logic                             cfg_wr_en,
	input  logic [rsbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsbf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [rsbf_pkg::WIN_W-1:0]      window_q;
	logic [rsbf_pkg::CHAN_CNT_W-1:0] channels_q;

	logic              q_push;
	logic              q_pop;
	rsbf_pkg::entry_t  q_wr_entry;
	rsbf_pkg::entry_t  q_rd_entry;
	rsbf_pkg::q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= rsbf_pkg::WINDOW_RESET;
			channels_q <= rsbf_pkg::CHANNELS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rsbf_pkg::REG_WINDOW: begin
					window_q <= cfg_data;
				end
				rsbf_pkg::REG_CHANNELS: begin
					channels_q <= cfg_data[rsbf_pkg::CHAN_CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rsbf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.src           (pixels),
		.window_size   (window_q),
		.channel_count (channels_q),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_entry       (q_wr_entry)
	);

	rsbf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_wr_entry),
		.pop        (q_pop),
		.pop_entry  (q_rd_entry),
		.stat       (q_stat)
	);

	rsbf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.q_entry (q_rd_entry),
		.q_pop   (q_pop),
		.dst     (results)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue pop while empty");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready) |-> !q_stat.full)
		else $error("item taken with no queue space");

endmodule
